FILE: rtl/frx_pkg.sv
// Package with the shared constants and types of the framed packet receiver.
package frx_pkg;

  localparam int unsigned MAX_PAYLOAD = 32;
  localparam int unsigned IDX_W       = $clog2(MAX_PAYLOAD);
  localparam int unsigned LEN_W       = $clog2(MAX_PAYLOAD + 1);

  localparam int unsigned CFG_ADDR_W  = 4;

  // Register indexes on the configuration port (byte address = 4 * index).
  localparam logic [1:0] REG_START_FIRST  = 2'd0;
  localparam logic [1:0] REG_START_SECOND = 2'd1;
  localparam logic [1:0] REG_MAX_LENGTH   = 2'd2;

  typedef enum logic {
    ALU_ADD,
    ALU_EQ
  } alu_op_e;

  typedef struct packed {
    alu_op_e    op;
    logic [7:0] a;
    logic [7:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [7:0] sum;
    logic       eq;
  } alu_rsp_t;

  typedef struct packed {
    logic [7:0] start_first;
    logic [7:0] start_second;
    logic [5:0] max_length;
  } cfg_t;

endpackage

FILE: rtl/frx_if.sv
// Valid/ready channel interfaces for received bytes and payload results.
interface frx_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface frx_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic [4:0] byte_index;
  logic [5:0] frame_length;
  logic       last_byte;

  modport source (
    output valid, output payload_byte, output byte_index, output frame_length,
    output last_byte, input ready
  );
  modport sink (
    input valid, input payload_byte, input byte_index, input frame_length,
    input last_byte, output ready
  );
endinterface

FILE: rtl/frx_alu.sv
// Shared 8-bit adder and equality compare used by the receiver sequencer.
module frx_alu (
  input  frx_pkg::alu_req_t req_i,
  output frx_pkg::alu_rsp_t rsp_o
);

  logic [7:0] sum;

  assign sum       = req_i.a + ((req_i.op == frx_pkg::ALU_ADD) ? req_i.b : ~req_i.b)
                     + ((req_i.op == frx_pkg::ALU_ADD) ? 8'd0 : 8'd1);
  assign rsp_o.sum = sum;
  // Equality falls out of the subtract: a - b is zero only when a equals b.
  assign rsp_o.eq  = (req_i.op == frx_pkg::ALU_EQ) && (sum == 8'd0);

endmodule

FILE: rtl/frx_cfg.sv
// APB-style configuration registers of the framed packet receiver.
module frx_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [frx_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output frx_pkg::cfg_t                    cfg_o
);

  frx_pkg::cfg_t cfg_q;
  logic          wr_en;
  logic [1:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_first  <= 8'd0;
      cfg_q.start_second <= 8'd0;
      cfg_q.max_length   <= 6'd32;
    end else if (wr_en) begin
      case (reg_idx)
        frx_pkg::REG_START_FIRST:  cfg_q.start_first  <= pwdata[7:0];
        frx_pkg::REG_START_SECOND: cfg_q.start_second <= pwdata[7:0];
        frx_pkg::REG_MAX_LENGTH:   cfg_q.max_length   <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      frx_pkg::REG_START_FIRST:  prdata = {24'd0, cfg_q.start_first};
      frx_pkg::REG_START_SECOND: prdata = {24'd0, cfg_q.start_second};
      frx_pkg::REG_MAX_LENGTH:   prdata = {26'd0, cfg_q.max_length};
      default:                   prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/framed_packet_receiver.sv
// Top level of the framed packet receiver: sequencer, payload store and result register.
// The receiver takes one serial byte per input beat and hunts for the two configured
// start bytes, then a length byte between 1 and the configured maximum (a maximum above
// the 32-entry store acts as 32). The payload bytes go into a 32-entry store while two
// 8-bit Fletcher-style sums, both seeded with the length, are kept by one shared adder.
// Header, length and checksum bytes each pass through one state; a payload byte passes
// through S_DATA and then S_SUM2, because the adder first adds the byte into the running
// sum and then adds the running sum into the sum of sums. When the second checksum byte
// matches, the receiver stops taking input and drains the stored payload, each result beat
// a store read followed by a load of the output register, held while the consumer stalls;
// the last beat of a frame carries last_byte. A finished result waits in the output
// register, so hunting for the next frame continues while it is unclaimed.
module framed_packet_receiver (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  frx_rx_if.sink                         rx_i,
  frx_res_if.source                      res_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [frx_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int unsigned IDX_W = frx_pkg::IDX_W;
  localparam int unsigned LEN_W = frx_pkg::LEN_W;

  typedef enum logic [2:0] {
    S_START1,
    S_START2,
    S_LENGTH,
    S_DATA,
    S_SUM2,
    S_CHECK1,
    S_CHECK2,
    S_DRAIN
  } state_e;

  frx_pkg::cfg_t     cfg;
  frx_pkg::alu_req_t alu_req;
  frx_pkg::alu_rsp_t alu_rsp;

  state_e            state_q;
  logic              rd_phase_q;   // 0: read the store, 1: load the output register
  logic [LEN_W-1:0]  len_q;
  logic [LEN_W-1:0]  cnt_q;
  logic [IDX_W-1:0]  rd_q;
  logic [7:0]        run_q;
  logic [7:0]        sos_q;
  logic [7:0]        rdata_q;
  logic [7:0]        store_q [frx_pkg::MAX_PAYLOAD];

  logic              out_valid_q;
  logic [7:0]        out_byte_q;
  logic [4:0]        out_index_q;
  logic [5:0]        out_len_q;
  logic              out_last_q;

  logic              rx_fire;
  logic              slot_free;
  logic              out_load;
  logic              drain_last;
  logic [7:0]        len_limit;
  logic              len_ok;

  frx_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  frx_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  // The sequencer steers the one adder/comparator to whatever the current phase needs.
  always_comb begin
    case (state_q)
      S_START1: alu_req = '{op: frx_pkg::ALU_EQ,  a: rx_i.rx_byte, b: cfg.start_first};
      S_START2: alu_req = '{op: frx_pkg::ALU_EQ,  a: rx_i.rx_byte, b: cfg.start_second};
      S_DATA:   alu_req = '{op: frx_pkg::ALU_ADD, a: run_q,        b: rx_i.rx_byte};
      S_SUM2:   alu_req = '{op: frx_pkg::ALU_ADD, a: sos_q,        b: run_q};
      S_CHECK1: alu_req = '{op: frx_pkg::ALU_EQ,  a: rx_i.rx_byte, b: run_q};
      S_CHECK2: alu_req = '{op: frx_pkg::ALU_EQ,  a: rx_i.rx_byte, b: sos_q};
      default:  alu_req = '{op: frx_pkg::ALU_EQ,  a: 8'd0,         b: 8'd0};
    endcase
  end

  // Input is taken in every phase except the second sum step and the payload drain.
  always_comb begin
    case (state_q)
      S_SUM2, S_DRAIN: rx_i.ready = 1'b0;
      default:         rx_i.ready = 1'b1;
    endcase
  end

  assign rx_fire = rx_i.valid && rx_i.ready;

  // A configured maximum above the store depth is clamped to the depth.
  assign len_limit = (8'(cfg.max_length) > 8'(frx_pkg::MAX_PAYLOAD))
                     ? 8'(frx_pkg::MAX_PAYLOAD) : 8'(cfg.max_length);
  assign len_ok    = (rx_i.rx_byte != 8'd0) && (rx_i.rx_byte <= len_limit);

  assign slot_free  = !out_valid_q || res_o.ready;
  // The output register takes a drained byte in the second drain phase once it is free.
  assign out_load   = (state_q == S_DRAIN) && rd_phase_q && slot_free;
  assign drain_last = (LEN_W'(rd_q) + LEN_W'(1)) == len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_START1;
      rd_phase_q  <= 1'b0;
      len_q       <= '0;
      cnt_q       <= '0;
      rd_q        <= '0;
      run_q       <= 8'd0;
      sos_q       <= 8'd0;
      out_valid_q <= 1'b0;
      out_byte_q  <= 8'd0;
      out_index_q <= 5'd0;
      out_len_q   <= 6'd0;
      out_last_q  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_START1: begin
          if (rx_fire && alu_rsp.eq) begin
            state_q <= S_START2;
          end
        end
        S_START2: begin
          if (rx_fire) begin
            state_q <= alu_rsp.eq ? S_LENGTH : S_START1;
          end
        end
        S_LENGTH: begin
          if (rx_fire) begin
            if (len_ok) begin
              len_q   <= LEN_W'(rx_i.rx_byte);
              cnt_q   <= '0;
              run_q   <= rx_i.rx_byte;
              sos_q   <= rx_i.rx_byte;
              state_q <= S_DATA;
            end else begin
              state_q <= S_START1;
            end
          end
        end
        S_DATA: begin
          if (rx_fire) begin
            run_q   <= alu_rsp.sum;
            cnt_q   <= cnt_q + LEN_W'(1);
            state_q <= S_SUM2;
          end
        end
        S_SUM2: begin
          sos_q   <= alu_rsp.sum;
          state_q <= (cnt_q >= len_q) ? S_CHECK1 : S_DATA;
        end
        S_CHECK1: begin
          if (rx_fire) begin
            state_q <= alu_rsp.eq ? S_CHECK2 : S_START1;
          end
        end
        S_CHECK2: begin
          if (rx_fire) begin
            if (alu_rsp.eq) begin
              rd_q       <= '0;
              rd_phase_q <= 1'b0;
              state_q    <= S_DRAIN;
            end else begin
              state_q <= S_START1;
            end
          end
        end
        S_DRAIN: begin
          if (!rd_phase_q) begin
            rd_phase_q <= 1'b1;
          end else if (slot_free) begin
            out_byte_q  <= rdata_q;
            out_index_q <= 5'(rd_q);
            out_len_q   <= 6'(len_q);
            out_last_q  <= drain_last;
            rd_phase_q  <= 1'b0;
            if (drain_last) begin
              state_q <= S_START1;
            end else begin
              rd_q <= rd_q + IDX_W'(1);
            end
          end
        end
        default: state_q <= S_START1;
      endcase
    end
  end

  // Payload store: written by accepted payload beats, read once per drained byte.
  always_ff @(posedge clk_i) begin
    if (rx_fire && state_q == S_DATA) begin
      store_q[cnt_q[IDX_W-1:0]] <= rx_i.rx_byte;
    end
    if (state_q == S_DRAIN && !rd_phase_q) begin
      rdata_q <= store_q[rd_q];
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.payload_byte = out_byte_q;
  assign res_o.byte_index   = out_index_q;
  assign res_o.frame_length = out_len_q;
  assign res_o.last_byte    = out_last_q;

  // A matching second checksum must start the drain.
  a_check_pass_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rx_fire && state_q == S_CHECK2 && alu_rsp.eq) |=> state_q == S_DRAIN)
    else $error("passing frame did not start the payload drain");

  // The payload counter never passes the frame length while a frame is in progress.
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DATA || state_q == S_SUM2 || state_q == S_CHECK1 ||
     state_q == S_CHECK2) |-> (cnt_q <= len_q && len_q != '0))
    else $error("payload count outside the frame length");

  // The flagged beat is always the final position of its frame.
  a_last_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> (6'(out_index_q) + 6'd1 == out_len_q))
    else $error("last beat not at the end of the frame");

  // Every drained beat lies inside the frame it belongs to.
  a_index_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (6'(out_index_q) < out_len_q))
    else $error("result index beyond the frame length");

endmodule

FILE: bench/frx_frame_checker.sv
// Checker for the framed packet receiver: frame parser prediction and payload beat scoreboard.
`timescale 1ns / 1ps

module frx_frame_checker
  import frx_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  frx_rx_if                     rx_i,
  frx_res_if                    res_i,
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic [CFG_ADDR_W-1:0] paddr_i,
  input  logic [31:0]           pwdata_i,
  input  logic                  pready_i,
  output int                    mismatches_o,
  output int                    outstanding_o,
  output int                    beats_checked_o
);

  typedef enum logic [2:0] {
    SEEK_FIRST,
    SEEK_SECOND,
    READ_LENGTH,
    READ_PAYLOAD,
    MATCH_RUN_SUM,
    MATCH_SUM_OF_SUMS
  } parse_e;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic [4:0] byte_index;
    logic [5:0] frame_length;
    logic       last_byte;
  } payload_beat_t;

  // Register copies, kept up to date by watching writes on the configuration port.
  logic [7:0]    cfg_first;
  logic [7:0]    cfg_second;
  logic [5:0]    cfg_max;

  parse_e        phase_q;
  logic [5:0]    frame_len;
  logic [5:0]    payload_count;
  logic [7:0]    run_sum;
  logic [7:0]    run_sos;
  logic [7:0]    payload_mem [MAX_PAYLOAD];

  payload_beat_t payload_beats [$];
  int            mismatch_count;
  int            beats_checked;

  task automatic report_mismatch(input string msg);
    $display("%0t ns frame checker: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_beat();
    payload_beat_t got;
    payload_beat_t want;
    got.payload_byte = res_i.payload_byte;
    got.byte_index   = res_i.byte_index;
    got.frame_length = res_i.frame_length;
    got.last_byte    = res_i.last_byte;
    beats_checked++;
    if (payload_beats.size() == 0) begin
      report_mismatch($sformatf(
        "beat with nothing expected: byte %02h index %0d length %0d last %0b",
        got.payload_byte, got.byte_index, got.frame_length, got.last_byte));
    end else begin
      want = payload_beats.pop_front();
      if (got !== want) begin
        report_mismatch($sformatf(
          "got byte %02h index %0d length %0d last %0b, expected %02h %0d %0d %0b",
          got.payload_byte, got.byte_index, got.frame_length, got.last_byte,
          want.payload_byte, want.byte_index, want.frame_length, want.last_byte));
      end
    end
  endtask

  task automatic take_byte(input logic [7:0] b);
    int cap;
    cap = (cfg_max > MAX_PAYLOAD) ? MAX_PAYLOAD : cfg_max;
    case (phase_q)
      SEEK_FIRST: begin
        if (b == cfg_first) phase_q = SEEK_SECOND;
      end
      // A wrong second byte is dropped, not retried as a first start byte.
      SEEK_SECOND: phase_q = (b == cfg_second) ? READ_LENGTH : SEEK_FIRST;
      READ_LENGTH: begin
        if (b == 0 || b > cap) begin
          phase_q = SEEK_FIRST;
        end else begin
          frame_len     = b[5:0];
          payload_count = '0;
          run_sum       = b;
          run_sos       = b;
          phase_q       = READ_PAYLOAD;
        end
      end
      READ_PAYLOAD: begin
        if (payload_count < MAX_PAYLOAD) payload_mem[payload_count[4:0]] = b;
        payload_count++;
        run_sum += b;
        run_sos += run_sum;
        if (payload_count >= frame_len) phase_q = MATCH_RUN_SUM;
      end
      MATCH_RUN_SUM: phase_q = (b == run_sum) ? MATCH_SUM_OF_SUMS : SEEK_FIRST;
      MATCH_SUM_OF_SUMS: begin
        phase_q = SEEK_FIRST;
        if (b == run_sos) begin
          for (int k = 0; k < frame_len; k++) begin
            payload_beats.push_back(payload_beat_t'{
              payload_byte: payload_mem[5'(k)],
              byte_index:   5'(k),
              frame_length: frame_len,
              last_byte:    (k + 1 == frame_len)});
          end
        end
      end
      default: phase_q = SEEK_FIRST;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_first      = '0;
      cfg_second     = '0;
      cfg_max        = 6'd32;
      phase_q        = SEEK_FIRST;
      frame_len      = '0;
      payload_count  = '0;
      run_sum        = '0;
      run_sos        = '0;
      mismatch_count = 0;
      beats_checked  = 0;
      payload_beats.delete();
      mismatches_o    <= 0;
      outstanding_o   <= 0;
      beats_checked_o <= 0;
    end else begin
      if (res_i.valid && res_i.ready) check_beat();
      if (rx_i.valid && rx_i.ready) take_byte(rx_i.rx_byte);
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[CFG_ADDR_W-1:2])
          REG_START_FIRST:  cfg_first  = pwdata_i[7:0];
          REG_START_SECOND: cfg_second = pwdata_i[7:0];
          REG_MAX_LENGTH:   cfg_max    = pwdata_i[5:0];
          default: ;
        endcase
      end
      mismatches_o    <= mismatch_count;
      outstanding_o   <= payload_beats.size();
      beats_checked_o <= beats_checked;
    end
  end

endmodule

FILE: bench/framed_packet_receiver_test.sv
// Top of the framed packet receiver testbench: clock, reset, frame stimulus and verdict.
`timescale 1ns / 1ps

module framed_packet_receiver_test;
  import frx_pkg::*;

  // Ways in which a generated frame can be spoiled on purpose.
  typedef enum int {
    FAULT_NONE,
    FAULT_START,
    FAULT_SUM,
    FAULT_SUM_OF_SUMS
  } frame_fault_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  frx_rx_if  rx ();
  frx_res_if res ();

  int mismatches;
  int expected_left;
  int beats_checked;

  // Handshake pressure, in percent of cycles, for the byte sender and the result taker.
  int rx_gap_pct;
  int res_stall_pct;

  // The testbench's own view of the framing registers, used to build frames.
  logic [7:0] sof_first;
  logic [7:0] sof_second;
  int         len_cap;

  int frame_bytes;
  int frames_sent;
  int cfg_writes;

  framed_packet_receiver dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx_i    (rx),
    .res_o   (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // The checker watches both channels and the configuration port beside the block.
  frx_frame_checker u_frame_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rx_i            (rx),
    .res_i           (res),
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .pready_i        (pready),
    .mismatches_o    (mismatches),
    .outstanding_o   (expected_left),
    .beats_checked_o (beats_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Result side: ready is redrawn every cycle, so a stall can land on any beat of a drain.
  // It stays low while reset is held.
  initial begin
    res.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      res.ready <= rst_ni && ($urandom_range(99) >= res_stall_pct);
    end
  end

  // Hard stop in case the block hangs; far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("framed_packet_receiver_test: errors");
    $finish;
  end

  // Sends one byte. Valid is only lowered for a gap, and only in a step where it is not
  // also raised, so a byte that follows straight on keeps valid high without a glitch.
  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(99) < rx_gap_pct) begin
      rx.valid <= 1'b0;
      @(posedge clk_i);
    end
    rx.valid   <= 1'b1;
    rx.rx_byte <= b;
    do @(posedge clk_i); while (!rx.ready);
  endtask

  // One register write: a setup phase, then an access phase held until pready.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    cfg_writes++;
  endtask

  task automatic set_config(input logic [7:0] first, input logic [7:0] second,
                            input logic [5:0] max_len);
    write_reg(REG_START_FIRST, {24'd0, first});
    write_reg(REG_START_SECOND, {24'd0, second});
    write_reg(REG_MAX_LENGTH, {26'd0, max_len});
    sof_first  = first;
    sof_second = second;
    // A maximum above the store size behaves like the store size.
    len_cap    = (max_len > MAX_PAYLOAD) ? MAX_PAYLOAD : max_len;
  endtask

  // Stops sending, waits for every predicted beat to come out, then lets the block finish
  // any payload byte still in its add sequence (S_DATA, then S_SUM2) before the caller goes on.
  task automatic settle(input int pause);
    int waited;
    waited = 0;
    rx.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_left != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (pause) @(posedge clk_i);
  endtask

  // Builds and sends one frame with the current start bytes. A negative fill draws random
  // payload bytes. Lengths above the store only carry two body bytes, since the block drops
  // such a frame at the length byte and everything after it is line noise anyway.
  task automatic push_frame(input int len, input frame_fault_e fault, input int fill);
    logic [7:0] run_sum;
    logic [7:0] run_sos;
    logic [7:0] b;
    int         body;
    run_sum = 8'(len);
    run_sos = 8'(len);
    body    = (len > MAX_PAYLOAD) ? 2 : len;
    push_byte(sof_first);
    if (fault == FAULT_START) begin
      // Where possible the wrong second byte repeats the first start byte, which must not
      // restart the frame.
      b = (sof_first != sof_second) ? sof_first : sof_second ^ 8'($urandom_range(1, 255));
      push_byte(b);
    end else begin
      push_byte(sof_second);
    end
    push_byte(8'(len));
    for (int k = 0; k < body; k++) begin
      b = (fill < 0) ? 8'($urandom_range(255)) : 8'(fill);
      push_byte(b);
      run_sum += b;
      run_sos += run_sum;
    end
    push_byte((fault == FAULT_SUM) ? run_sum ^ (8'd1 << $urandom_range(7)) : run_sum);
    push_byte((fault == FAULT_SUM_OF_SUMS) ? run_sos ^ (8'd1 << $urandom_range(7)) : run_sos);
    frame_bytes += body + 5;
    frames_sent++;
  endtask

  // Mostly intact frames with short payloads; now and then a long one, a spoiled one,
  // an out-of-range length, or a short burst of noise on the line.
  task automatic push_random_frame();
    int pick;
    int len;
    pick = $urandom_range(99);
    len  = ($urandom_range(9) == 0) ? $urandom_range(1, len_cap)
                                    : $urandom_range(1, (len_cap < 8) ? len_cap : 8);
    if (pick < 68) begin
      push_frame(len, FAULT_NONE, -1);
    end else if (pick < 76) begin
      push_frame(len, FAULT_SUM, -1);
    end else if (pick < 84) begin
      push_frame(len, FAULT_SUM_OF_SUMS, -1);
    end else if (pick < 90) begin
      push_frame(len, FAULT_START, -1);
    end else if (pick < 95) begin
      push_frame($urandom_range(1) ? 0 : $urandom_range(len_cap + 1, 255), FAULT_NONE, -1);
    end else begin
      repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(255)));
    end
  endtask

  initial begin
    int phase_start;
    rst_ni        <= 1'b0;
    rx.valid      <= 1'b0;
    rx.rx_byte    <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    rx_gap_pct    = 26;
    res_stall_pct = 46;
    sof_first     = 8'h00;
    sof_second    = 8'h00;
    len_cap       = MAX_PAYLOAD;
    frame_bytes   = 0;
    frames_sent   = 0;
    cfg_writes    = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. Registers still hold their reset values: both start bytes zero and
    // the full store length, so an all-zero frame and an all-ones frame come first.
    push_frame(1, FAULT_NONE, 8'h00);
    push_frame(2, FAULT_NONE, 8'hFF);

    // A maximum of 63 must act as 32: a full frame passes, 33 and the extreme lengths fail.
    settle(8);
    set_config(8'hFF, 8'h00, 6'd63);
    push_frame(MAX_PAYLOAD, FAULT_NONE, 8'hFF);
    push_frame(MAX_PAYLOAD + 1, FAULT_NONE, -1);
    push_frame(0, FAULT_NONE, -1);
    push_frame(255, FAULT_NONE, -1);
    push_frame(3, FAULT_NONE, -1);

    // Smallest useful maximum with equal start bytes, then each checksum failure.
    settle(8);
    set_config(8'h7E, 8'h7E, 6'd1);
    push_frame(1, FAULT_NONE, -1);
    push_frame(2, FAULT_NONE, -1);
    push_frame(1, FAULT_SUM, -1);
    push_frame(1, FAULT_SUM_OF_SUMS, -1);
    push_frame(1, FAULT_NONE, -1);

    // Distinct start bytes: a repeated first start byte in place of the second is dropped.
    settle(8);
    set_config(8'hA5, 8'h5A, 6'd4);
    push_frame(2, FAULT_START, -1);
    push_frame(4, FAULT_NONE, -1);

    // A maximum of zero rejects every length.
    settle(8);
    set_config(8'hA5, 8'h5A, 6'd0);
    push_frame(1, FAULT_NONE, -1);
    push_frame(MAX_PAYLOAD, FAULT_NONE, -1);

    // Random part in three handshake mixes, each with fresh start bytes and its own maximum:
    // the full store, one drawn below it, and one drawn above it.
    for (int mix = 0; mix < 3; mix++) begin
      settle(8);
      case (mix)
        0: begin
          rx_gap_pct    = 26;
          res_stall_pct = 46;
          set_config(8'($urandom_range(255)), 8'($urandom_range(255)), 6'd32);
        end
        1: begin
          rx_gap_pct    = 46;
          res_stall_pct = 26;
          set_config(8'($urandom_range(255)), 8'($urandom_range(255)),
                     6'($urandom_range(8, 31)));
        end
        default: begin
          rx_gap_pct    = 0;
          res_stall_pct = 0;
          set_config(8'($urandom_range(255)), 8'($urandom_range(255)),
                     6'($urandom_range(33, 63)));
        end
      endcase
      phase_start = frame_bytes;
      while (frame_bytes - phase_start < 28) push_random_frame();
    end

    settle(16);
    $display("Sent %0d framed bytes in %0d frames under three idle mixes, %0d register writes.",
             frame_bytes, frames_sent, cfg_writes);
    $display("%0d payload beats came out and were compared with the predicted frames.",
             beats_checked);
    if (mismatches == 0 && expected_left == 0) begin
      $display("framed_packet_receiver_test: clean");
    end else begin
      $display("framed_packet_receiver_test: errors");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/frx_pkg.sv
rtl/frx_if.sv
rtl/frx_alu.sv
rtl/frx_cfg.sv
rtl/framed_packet_receiver.sv
bench/frx_frame_checker.sv
bench/framed_packet_receiver_test.sv
